/* design/ltsp_pkg.sv */
// ----------------------------------------------------------------------------
// ltsp_pkg: shared types and constants for the line tracking steering block
// Holds the register map, configuration record, status codes and the
// fixed pattern-to-error table used by the control stage.
// ----------------------------------------------------------------------------
package ltsp_pkg;

	localparam int CHANNELS    = 8;
	localparam int SAMPLE_BITS = 12;
	localparam int DRIVE_BITS  = 5;
	localparam int ERR_BITS    = 4;
	localparam int LOST_BITS   = 9;
	localparam int LIMIT_BITS  = 8;
	localparam int ADDR_BITS   = 5;
	localparam int DATA_BITS   = 32;

	// Input and output bus widths, packed lowest field first.
	localparam int IN_DATA_BITS  = CHANNELS * SAMPLE_BITS;
	localparam int OUT_RAW_BITS  = 3 * DRIVE_BITS + CHANNELS + SAMPLE_BITS;
	localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

	localparam logic [DRIVE_BITS-1:0] DRIVE_CAP     = DRIVE_BITS'(20);
	localparam logic [LOST_BITS-1:0]  LOST_SAT      = LOST_BITS'(511);
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX   = '1;

	// Register indexes, one 32-bit word each.
	typedef enum logic [2:0] {
		REG_THRESHOLD  = 3'd0,
		REG_BASE_SPEED = 3'd1,
		REG_DRIVE_MIN  = 3'd2,
		REG_DRIVE_MAX  = 3'd3,
		REG_LOST_LEFT  = 3'd4,
		REG_LOST_RIGHT = 3'd5,
		REG_LOST_LIMIT = 3'd6
	} reg_idx_t;

	// Tracking status reported with every result.
	typedef enum logic [1:0] {
		ST_TRACK = 2'd0,
		ST_LOST  = 2'd1,
		ST_EXIT  = 2'd2
	} status_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] threshold;
		logic [DRIVE_BITS-1:0]  base_speed;
		logic [DRIVE_BITS-1:0]  drive_min;
		logic [DRIVE_BITS-1:0]  drive_max;
		logic [DRIVE_BITS-1:0]  lost_left;
		logic [DRIVE_BITS-1:0]  lost_right;
		logic [LIMIT_BITS-1:0]  lost_limit;
	} cfg_t;

	typedef struct packed {
		logic                       hit;
		logic signed [ERR_BITS-1:0] err;
	} map_t;

	// Fixed mapping from a nonzero line pattern to a signed steering error.
	function automatic map_t map_pattern(input logic [CHANNELS-1:0] p);
		map_t m;
		m.hit = 1'b1;
		m.err = '0;
		case (p)
			8'h10, 8'h08: m.err = 4'sd1;
			8'h18, 8'h3C, 8'h7E: m.err = 4'sd0;
			8'h30, 8'h20: m.err = 4'sd2;
			8'h40, 8'h60: m.err = 4'sd4;
			8'h80, 8'hC0, 8'hE0, 8'hA0,
			8'hFE, 8'hFC, 8'hF8, 8'hF0: m.err = 4'sd6;
			8'h7C, 8'h78: m.err = 4'sd4;
			8'h38, 8'h0C, 8'h1C: m.err = 4'sd2;
			8'h04: m.err = -4'sd2;
			8'h0E, 8'h1E, 8'h3E: m.err = -4'sd4;
			8'h1F, 8'h3F, 8'h7D: m.err = -4'sd6;
			8'h02, 8'h06: m.err = -4'sd4;
			8'h01, 8'h03, 8'h07, 8'h0F: m.err = -4'sd6;
			default: m.hit = 1'b0;
		endcase
		return m;
	endfunction

endpackage

/* design/ltsp_regs.sv */
// ----------------------------------------------------------------------------
// ltsp_regs: configuration register file
// APB-style slave holding the seven tuning registers; pready is tied high
// and reads return the stored register value.
// ----------------------------------------------------------------------------
module ltsp_regs
	import ltsp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= SAMPLE_BITS'(2400);
			cfg_q.base_speed <= DRIVE_BITS'(10);
			cfg_q.drive_min  <= DRIVE_BITS'(2);
			cfg_q.drive_max  <= DRIVE_BITS'(16);
			cfg_q.lost_left  <= DRIVE_BITS'(8);
			cfg_q.lost_right <= DRIVE_BITS'(14);
			cfg_q.lost_limit <= LIMIT_BITS'(160);
		end else if (wr_en) begin
			case (idx)
				REG_THRESHOLD:  cfg_q.threshold  <= pwdata[SAMPLE_BITS-1:0];
				REG_BASE_SPEED: cfg_q.base_speed <= pwdata[DRIVE_BITS-1:0];
				REG_DRIVE_MIN:  cfg_q.drive_min  <= pwdata[DRIVE_BITS-1:0];
				REG_DRIVE_MAX:  cfg_q.drive_max  <= pwdata[DRIVE_BITS-1:0];
				REG_LOST_LEFT:  cfg_q.lost_left  <= pwdata[DRIVE_BITS-1:0];
				REG_LOST_RIGHT: cfg_q.lost_right <= pwdata[DRIVE_BITS-1:0];
				REG_LOST_LIMIT: cfg_q.lost_limit <= pwdata[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back mux.
	always_comb begin
		prdata = '0;
		case (idx)
			REG_THRESHOLD:  prdata = DATA_BITS'(cfg_q.threshold);
			REG_BASE_SPEED: prdata = DATA_BITS'(cfg_q.base_speed);
			REG_DRIVE_MIN:  prdata = DATA_BITS'(cfg_q.drive_min);
			REG_DRIVE_MAX:  prdata = DATA_BITS'(cfg_q.drive_max);
			REG_LOST_LEFT:  prdata = DATA_BITS'(cfg_q.lost_left);
			REG_LOST_RIGHT: prdata = DATA_BITS'(cfg_q.lost_right);
			REG_LOST_LIMIT: prdata = DATA_BITS'(cfg_q.lost_limit);
			default:        prdata = '0;
		endcase
	end

endmodule

/* design/ltsp_lane.sv */
// ----------------------------------------------------------------------------
// ltsp_lane: one sensor channel
// Compares its sample against the threshold and registers the detect bit
// together with the sample for the merging stage.
// ----------------------------------------------------------------------------
module ltsp_lane
	import ltsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   en,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic [SAMPLE_BITS-1:0] threshold,
	output logic                   hit_s1,
	output logic [SAMPLE_BITS-1:0] sample_s1
);

	// Detect flag and sample captured when the transaction enters stage one.
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s1    <= (sample < threshold);
			sample_s1 <= sample;
		end
	end

endmodule

/* design/ltsp_merge.sv */
// ----------------------------------------------------------------------------
// ltsp_merge: lane merge
// Packs the lane detect bits into the line pattern (channel 0 at the MSB)
// and finds the smallest sample with a three-level compare tree.
// ----------------------------------------------------------------------------
module ltsp_merge
	import ltsp_pkg::*;
(
	input  logic [CHANNELS-1:0]                   hits,
	input  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  samples,
	output logic [CHANNELS-1:0]                   pattern,
	output logic [SAMPLE_BITS-1:0]                min_val
);

	logic [3:0][SAMPLE_BITS-1:0] lvl1;
	logic [1:0][SAMPLE_BITS-1:0] lvl2;
	logic [SAMPLE_BITS-1:0]      lvl3;

	// Channel i lands at bit CHANNELS-1-i.
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			pattern[CHANNELS-1-i] = hits[i];
		end
	end

	// Pairwise minimum tree over the eight lanes.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lvl1[i] = (samples[2*i+1] < samples[2*i]) ? samples[2*i+1] : samples[2*i];
		end
		for (int i = 0; i < 2; i++) begin
			lvl2[i] = (lvl1[2*i+1] < lvl1[2*i]) ? lvl1[2*i+1] : lvl1[2*i];
		end
		lvl3 = (lvl2[1] < lvl2[0]) ? lvl2[1] : lvl2[0];
		min_val = (lvl3 < SAMPLE_MAX) ? lvl3 : SAMPLE_MAX;
	end

endmodule

/* design/ltsp_ctrl.sv */
// ----------------------------------------------------------------------------
// ltsp_ctrl: tracking state and PD steering stage
// Keeps the error history, lost count and exit flag, runs the PD step on
// the mapped error and registers the result fields for the output port.
// ----------------------------------------------------------------------------
module ltsp_ctrl
	import ltsp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  cfg_t                   cfg,
	input  logic                   restart,
	input  logic [CHANNELS-1:0]    pattern,
	input  logic [SAMPLE_BITS-1:0] min_val,
	output logic [DRIVE_BITS-1:0]  left_s2,
	output logic [DRIVE_BITS-1:0]  right_s2,
	output status_t                status_s2,
	output logic [CHANNELS-1:0]    pattern_s2,
	output logic [SAMPLE_BITS-1:0] min_s2,
	output logic [DRIVE_BITS-1:0]  steer_s2
);

	logic signed [ERR_BITS-1:0] prev_err_q, held_err_q;
	logic [LOST_BITS-1:0]       miss_cnt_q;
	logic                       exited_q;

	logic signed [ERR_BITS-1:0] prev_eff, held_eff, err;
	logic [LOST_BITS-1:0]       lost_eff, lost_inc;
	logic                       exited_eff;
	map_t                       map;
	logic signed [8:0]          err9, d9, num, adj, half, steer_c;
	logic signed [6:0]          base7, min7, max7, lv, rv;

	logic signed [ERR_BITS-1:0] prev_nxt, held_nxt;
	logic [LOST_BITS-1:0]       lost_nxt;
	logic                       exited_nxt;
	logic [DRIVE_BITS-1:0]      left_nxt, right_nxt, steer_nxt;
	status_t                    status_nxt;

	// A restart clears the history before the transaction is evaluated.
	assign prev_eff   = restart ? '0 : prev_err_q;
	assign held_eff   = restart ? '0 : held_err_q;
	assign lost_eff   = restart ? '0 : miss_cnt_q;
	assign exited_eff = restart ? 1'b0 : exited_q;

	assign map      = map_pattern(pattern);
	assign err      = map.hit ? map.err : held_eff;
	assign lost_inc = (lost_eff == LOST_SAT) ? lost_eff : lost_eff + 1'b1;

	// PD step in half units: num = 5e + 7d, then halve toward zero.
	always_comb begin
		err9 = 9'(err);
		if (prev_eff == '0 && err != '0) begin
			d9 = (err9 + $signed({8'd0, err9[8]})) >>> 1;
		end else begin
			d9 = err9 - 9'(prev_eff);
		end
		num  = 9'sd5 * err9 + 9'sd7 * d9;
		adj  = num + $signed({8'd0, num[8]});
		half = adj >>> 1;
		if (half > 9'sd10) begin
			steer_c = 9'sd10;
		end else if (half < -9'sd10) begin
			steer_c = -9'sd10;
		end else begin
			steer_c = half;
		end
	end

	// Wheel drives: raise to drive_min, lower to drive_max, cap at 20.
	always_comb begin
		base7 = $signed({2'b00, cfg.base_speed});
		min7  = $signed({2'b00, cfg.drive_min});
		max7  = $signed({2'b00, cfg.drive_max});
		lv    = base7 - 7'(steer_c);
		rv    = base7 + 7'(steer_c);
		if (lv < min7) lv = min7;
		if (lv > max7) lv = max7;
		if (lv > 7'sd20) lv = 7'sd20;
		if (rv < min7) rv = min7;
		if (rv > max7) rv = max7;
		if (rv > 7'sd20) rv = 7'sd20;
	end

	// Next state and result selection.
	always_comb begin
		prev_nxt   = prev_eff;
		held_nxt   = held_eff;
		lost_nxt   = lost_eff;
		exited_nxt = exited_eff;
		left_nxt   = '0;
		right_nxt  = '0;
		steer_nxt  = '0;
		status_nxt = ST_EXIT;
		if (exited_eff) begin
			status_nxt = ST_EXIT;
		end else if (pattern == '0) begin
			lost_nxt = lost_inc;
			if (lost_inc > LOST_BITS'(cfg.lost_limit)) begin
				exited_nxt = 1'b1;
				prev_nxt   = '0;
				status_nxt = ST_EXIT;
			end else begin
				status_nxt = ST_LOST;
				left_nxt   = (cfg.lost_left > DRIVE_CAP) ? DRIVE_CAP : cfg.lost_left;
				right_nxt  = (cfg.lost_right > DRIVE_CAP) ? DRIVE_CAP : cfg.lost_right;
			end
		end else begin
			lost_nxt   = '0;
			status_nxt = ST_TRACK;
			held_nxt   = err;
			prev_nxt   = err;
			steer_nxt  = DRIVE_BITS'(steer_c);
			left_nxt   = DRIVE_BITS'(lv);
			right_nxt  = DRIVE_BITS'(rv);
		end
	end

	// Tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_err_q <= '0;
			held_err_q <= '0;
			miss_cnt_q <= '0;
			exited_q   <= 1'b0;
		end else if (en) begin
			prev_err_q <= prev_nxt;
			held_err_q <= held_nxt;
			miss_cnt_q <= lost_nxt;
			exited_q   <= exited_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (en) begin
			left_s2    <= left_nxt;
			right_s2   <= right_nxt;
			status_s2  <= status_nxt;
			pattern_s2 <= pattern;
			min_s2     <= min_val;
			steer_s2   <= steer_nxt;
		end
	end

endmodule

/* design/line_track_steering_pd_top.sv */
// ----------------------------------------------------------------------------
// line_track_steering_pd_top: line tracking steering controller
// Flow: each input transaction is registered in the lane stage, then in the control result register.
// Throughput: one transaction per cycle, set by the two-stage lane/control
// pipeline, which advances whenever its output register is free or taken.
// Reset: arst_n clears pipeline valids, tracking state and registers to
// their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_track_steering_pd_top
	import ltsp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// APB-style configuration port
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_BITS-1:0]     paddr,
	input  logic [DATA_BITS-1:0]     pwdata,
	output logic [DATA_BITS-1:0]     prdata,
	output logic                     pready,
	// Input stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,  // sample0 .. sample7, 12 bits each
	input  logic                     s_tuser,  // restart
	// Output stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// left_drive, right_drive, line_pattern, min_sample, steer, zero pad
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic [1:0]               m_tuser   // track_status
);

	cfg_t                                cfg;
	logic                                valid_s1, restart_s1;
	logic                                out_valid_q;
	logic                                en_s1, en_s2;
	logic [CHANNELS-1:0]                 hits_s1;
	logic [CHANNELS-1:0][SAMPLE_BITS-1:0] samples_s1;
	logic [CHANNELS-1:0]                 pattern;
	logic [SAMPLE_BITS-1:0]              min_val;
	logic [DRIVE_BITS-1:0]               left_s2, right_s2, steer_s2;
	status_t                             status_s2;
	logic [CHANNELS-1:0]                 pattern_s2;
	logic [SAMPLE_BITS-1:0]              min_s2;

	ltsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline flow control: each stage moves when the stage after it frees up.
	assign en_s2    = !out_valid_q || m_tready;
	assign en_s1    = !valid_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= s_tvalid;
			if (en_s2) out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) restart_s1 <= s_tuser;
	end

	// Per-channel compare lanes.
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		ltsp_lane u_lane (
			.clk       (clk),
			.en        (en_s1),
			.sample    (s_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
			.threshold (cfg.threshold),
			.hit_s1    (hits_s1[g]),
			.sample_s1 (samples_s1[g])
		);
	end

	ltsp_merge u_merge (
		.hits    (hits_s1),
		.samples (samples_s1),
		.pattern (pattern),
		.min_val (min_val)
	);

	ltsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_s2 && valid_s1),
		.cfg        (cfg),
		.restart    (restart_s1),
		.pattern    (pattern),
		.min_val    (min_val),
		.left_s2    (left_s2),
		.right_s2   (right_s2),
		.status_s2  (status_s2),
		.pattern_s2 (pattern_s2),
		.min_s2     (min_s2),
		.steer_s2   (steer_s2)
	);

	// Output packing, lowest field first.
	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_s2;
	assign m_tdata  = OUT_DATA_BITS'({steer_s2, min_s2, pattern_s2, right_s2, left_s2});

endmodule

/* verif/line_track_steering_pd_chk.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_track_steering_pd_chk: result checker for the line tracking steering block
// Snoops the configuration port and both streams. For every accepted input
// transaction it computes the wheel command the block must return, queues it,
// and compares each accepted output transaction with the oldest one queued.
// ----------------------------------------------------------------------------
module line_track_steering_pd_chk
	import ltsp_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_BITS-1:0]     paddr,
	input  logic [DATA_BITS-1:0]     pwdata,
	input  logic                     pready,
	input  logic                     s_tvalid,
	input  logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // sample0 .. sample7, 12 bits each
	input  logic                     s_tuser,   // restart
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	// left_drive, right_drive, line_pattern, min_sample, steer, zero pad
	input  logic [OUT_DATA_BITS-1:0] m_tdata,
	input  logic [1:0]               m_tuser,   // track_status
	output int                       fail_count,
	output int                       pending,
	output int                       items_seen,
	output int                       track_seen,
	output int                       lost_seen,
	output int                       exit_seen,
	output int                       unknown_seen
);

	localparam int STEER_SPAN   = 10;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [DRIVE_BITS-1:0]        left;
		logic [DRIVE_BITS-1:0]        right;
		status_t                      status;
		logic [CHANNELS-1:0]          pattern;
		logic [SAMPLE_BITS-1:0]       min_sample;
		logic signed [DRIVE_BITS-1:0] steer;
	} wheel_cmd_t;

	// Shadow of the register file and of the tracking state.
	cfg_t                       cfg;
	logic signed [ERR_BITS-1:0] prev_err;
	logic signed [ERR_BITS-1:0] held_err;
	logic [LOST_BITS-1:0]       miss_cnt;
	logic                       exited;

	wheel_cmd_t wheel_cmd_q[$];

	// Signed position error for a line pattern; returns 0 for patterns off the table.
	function automatic bit line_offset(input logic [CHANNELS-1:0] pat, output int err);
		bit hit;
		hit = 1'b1;
		err = 0;
		case (pat)
			8'h08, 8'h10: err = 1;
			8'h18, 8'h3C, 8'h7E: err = 0;
			8'h0C, 8'h1C, 8'h20, 8'h30, 8'h38: err = 2;
			8'h40, 8'h60, 8'h78, 8'h7C: err = 4;
			8'h80, 8'hA0, 8'hC0, 8'hE0, 8'hF0, 8'hF8, 8'hFC, 8'hFE: err = 6;
			8'h04: err = -2;
			8'h02, 8'h06, 8'h0E, 8'h1E, 8'h3E: err = -4;
			8'h01, 8'h03, 8'h07, 8'h0F, 8'h1F, 8'h3F, 8'h7D: err = -6;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Every drive ends up at 20 or below.
	function automatic logic [DRIVE_BITS-1:0] drive_cap(input int v);
		if (v > int'(DRIVE_CAP)) begin
			v = DRIVE_CAP;
		end
		return DRIVE_BITS'(v);
	endfunction

	// Raise to the minimum first, then lower to the maximum, so the maximum wins.
	function automatic logic [DRIVE_BITS-1:0] track_drive(input int v);
		if (v < int'(cfg.drive_min)) begin
			v = cfg.drive_min;
		end
		if (v > int'(cfg.drive_max)) begin
			v = cfg.drive_max;
		end
		return drive_cap(v);
	endfunction

	// Advance the tracking state by one sample set and return the wheel command.
	function automatic wheel_cmd_t compute_wheel_cmd(input logic [IN_DATA_BITS-1:0] smp,
			input logic rst);
		wheel_cmd_t             c;
		logic [SAMPLE_BITS-1:0] s;
		int                     e, d, num, st, i;
		if (rst) begin
			prev_err = '0;
			held_err = '0;
			miss_cnt = '0;
			exited   = 1'b0;
		end
		c.pattern    = '0;
		c.min_sample = '1;
		c.left       = '0;
		c.right      = '0;
		st           = 0;
		for (i = 0; i < CHANNELS; i++) begin
			s = smp[i*SAMPLE_BITS +: SAMPLE_BITS];
			if (s < cfg.threshold) begin
				c.pattern[CHANNELS-1-i] = 1'b1;
			end
			if (s < c.min_sample) begin
				c.min_sample = s;
			end
		end
		if (exited) begin
			c.status = ST_EXIT;
		end else if (c.pattern == '0) begin
			// Line lost: count it and either apply the fixed pair or give up.
			if (miss_cnt != LOST_SAT) begin
				miss_cnt = miss_cnt + 1'b1;
			end
			if (miss_cnt > cfg.lost_limit) begin
				exited   = 1'b1;
				prev_err = '0;
				c.status = ST_EXIT;
			end else begin
				c.status = ST_LOST;
				c.left   = drive_cap(cfg.lost_left);
				c.right  = drive_cap(cfg.lost_right);
			end
		end else begin
			// Tracking: table error, PD step in halves, then the two drives.
			miss_cnt = '0;
			c.status = ST_TRACK;
			if (!line_offset(c.pattern, e)) begin
				e = held_err;
				unknown_seen++;
			end
			held_err = ERR_BITS'(e);
			if (prev_err == 0 && e != 0) begin
				d = e / 2;
			end else begin
				d = e - prev_err;
			end
			num = 5 * e + 7 * d;
			st  = num / 2;
			if (st > STEER_SPAN) begin
				st = STEER_SPAN;
			end
			if (st < -STEER_SPAN) begin
				st = -STEER_SPAN;
			end
			prev_err = ERR_BITS'(e);
			c.left   = track_drive(int'(cfg.base_speed) - st);
			c.right  = track_drive(int'(cfg.base_speed) + st);
		end
		c.steer = DRIVE_BITS'(st);
		return c;
	endfunction

	function automatic string show(input wheel_cmd_t c);
		return $sformatf("left=%0d right=%0d status=%0d pattern=%02h min=%0d steer=%0d",
			c.left, c.right, c.status, c.pattern, c.min_sample, c.steer);
	endfunction

	// Configuration writes, result checks and predictions, all on the clock edge.
	always @(posedge clk or negedge arst_n) begin : watch
		wheel_cmd_t want;
		wheel_cmd_t got;
		if (!arst_n) begin
			cfg.threshold  = 12'd2400;
			cfg.base_speed = 5'd10;
			cfg.drive_min  = 5'd2;
			cfg.drive_max  = 5'd16;
			cfg.lost_left  = 5'd8;
			cfg.lost_right = 5'd14;
			cfg.lost_limit = 8'd160;
			prev_err       = '0;
			held_err       = '0;
			miss_cnt       = '0;
			exited         = 1'b0;
			wheel_cmd_q.delete();
			pending        = 0;
		end else begin
			// Register write transaction.
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_BITS-1:2])
					REG_THRESHOLD:  cfg.threshold  = pwdata[SAMPLE_BITS-1:0];
					REG_BASE_SPEED: cfg.base_speed = pwdata[DRIVE_BITS-1:0];
					REG_DRIVE_MIN:  cfg.drive_min  = pwdata[DRIVE_BITS-1:0];
					REG_DRIVE_MAX:  cfg.drive_max  = pwdata[DRIVE_BITS-1:0];
					REG_LOST_LEFT:  cfg.lost_left  = pwdata[DRIVE_BITS-1:0];
					REG_LOST_RIGHT: cfg.lost_right = pwdata[DRIVE_BITS-1:0];
					REG_LOST_LIMIT: cfg.lost_limit = pwdata[LIMIT_BITS-1:0];
					default: ;
				endcase
			end
			// Output transaction against the oldest queued command.
			if (m_tvalid && m_tready) begin
				got.left       = m_tdata[4:0];
				got.right      = m_tdata[9:5];
				got.pattern    = m_tdata[17:10];
				got.min_sample = m_tdata[29:18];
				got.steer      = m_tdata[34:30];
				got.status     = status_t'(m_tuser);
				if (wheel_cmd_q.size() == 0) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT) begin
						$display("%t: result with nothing expected: %s", $time, show(got));
					end
				end else begin
					want = wheel_cmd_q.pop_front();
					if (want !== got) begin
						fail_count++;
						if (fail_count <= REPORT_LIMIT) begin
							$display("%t: wheel command mismatch", $time);
							$display("  expected %s", show(want));
							$display("  actual   %s", show(got));
						end
					end
				end
			end
			// Input transaction: predict its command.
			if (s_tvalid && s_tready) begin
				want = compute_wheel_cmd(s_tdata, s_tuser);
				wheel_cmd_q.push_back(want);
				items_seen++;
				case (want.status)
					ST_TRACK: track_seen++;
					ST_LOST:  lost_seen++;
					default:  exit_seen++;
				endcase
			end
			pending = wheel_cmd_q.size();
		end
	end

endmodule

/* verif/tb_line_track_steering_pd_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_track_steering_pd_top: testbench for the line tracking steering block
// Drives a short directed sequence and then phases of random sample sets under
// several register settings, with random idling on both streams and one long
// output stall. Checking is done by the companion checker module.
// ----------------------------------------------------------------------------
module tb_line_track_steering_pd_top;
	import ltsp_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 7;
	localparam int KNOWN_COUNT = 35;
	localparam logic [8*KNOWN_COUNT-1:0] KNOWN_PATS = {
		8'h10, 8'h08, 8'h18, 8'h3C, 8'h7E, 8'h30, 8'h20, 8'h40, 8'h60, 8'h80,
		8'hC0, 8'hE0, 8'hA0, 8'hFE, 8'hFC, 8'hF8, 8'hF0, 8'h7C, 8'h78, 8'h38,
		8'h0C, 8'h1C, 8'h04, 8'h0E, 8'h1E, 8'h3E, 8'h1F, 8'h3F, 8'h7D, 8'h02,
		8'h06, 8'h01, 8'h03, 8'h07, 8'h0F
	};

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [ADDR_BITS-1:0]     paddr;
	logic [DATA_BITS-1:0]     pwdata;
	logic [DATA_BITS-1:0]     prdata;
	logic                     pready;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_DATA_BITS-1:0]  s_tdata;   // sample0 .. sample7, 12 bits each
	logic                     s_tuser;   // restart
	logic                     m_tvalid;
	logic                     m_tready;
	// left_drive, right_drive, line_pattern, min_sample, steer, zero pad
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic [1:0]               m_tuser;   // track_status

	int fail_count, pending, items_seen, track_seen, lost_seen, exit_seen, unknown_seen;

	// Stimulus side copy of the settings that shape the sample sets.
	logic [SAMPLE_BITS-1:0] thr_now;
	logic [LIMIT_BITS-1:0]  limit_now;
	bit                     src_steady;
	bit                     hold_off_req;
	int                     settings_used;

	line_track_steering_pd_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	line_track_steering_pd_chk chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.items_seen   (items_seen),
		.track_seen   (track_seen),
		.lost_seen    (lost_seen),
		.exit_seen    (exit_seen),
		.unknown_seen (unknown_seen)
	);

	// 2 ns clock.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 85) begin
			return $urandom_range(1, 3);
		end
		if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Sample set that thresholds to the given pattern, often at the range edges.
	function automatic logic [IN_DATA_BITS-1:0] samples_for(input logic [CHANNELS-1:0] pat);
		logic [IN_DATA_BITS-1:0] d;
		int                      lo, hi, i;
		d = '0;
		for (i = 0; i < CHANNELS; i++) begin
			if (pat[CHANNELS-1-i] && thr_now != 0) begin
				lo = 0;
				hi = thr_now - 1;
			end else begin
				lo = thr_now;
				hi = 4095;
			end
			case ($urandom_range(0, 7))
				0: d[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(lo);
				1: d[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(hi);
				default: d[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'($urandom_range(lo, hi));
			endcase
		end
		return d;
	endfunction

	function automatic logic [CHANNELS-1:0] known_pattern();
		int k;
		k = $urandom_range(0, KNOWN_COUNT - 1);
		return KNOWN_PATS[k*8 +: 8];
	endfunction

	// Offer one sample set and hold it until the block takes the transaction.
	task automatic send_item(input logic [IN_DATA_BITS-1:0] d, input logic rst);
		int gap;
		gap = src_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= rst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_pat(input logic [CHANNELS-1:0] pat, input logic rst);
		send_item(samples_for(pat), rst);
	endtask

	// Setup then access cycle; psel stays up across back-to-back writes.
	task automatic apb_write(input reg_idx_t idx, input int unsigned val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic set_cfg(input int thr, input int base, input int dmin, input int dmax,
			input int lleft, input int lright, input int lim);
		apb_write(REG_THRESHOLD, thr);
		apb_write(REG_BASE_SPEED, base);
		apb_write(REG_DRIVE_MIN, dmin);
		apb_write(REG_DRIVE_MAX, dmax);
		apb_write(REG_LOST_LEFT, lleft);
		apb_write(REG_LOST_RIGHT, lright);
		apb_write(REG_LOST_LIMIT, lim);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		thr_now   = SAMPLE_BITS'(thr);
		limit_now = LIMIT_BITS'(lim);
		settings_used++;
	endtask

	// Stop offering and let every queued result drain before touching registers.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Edges of the fields, the table classes but for error 2, PD special cases, lost and restart.
	task automatic run_directed();
		logic [IN_DATA_BITS-1:0] d;
		send_item('0, 1'b1);
		send_item('1, 1'b0);
		d = {CHANNELS{12'd2400}};
		send_item(d, 1'b0);
		d[SAMPLE_BITS-1:0] = 12'd2399;
		send_item(d, 1'b0);
		send_pat(8'h01, 1'b0);
		send_pat(8'h04, 1'b0);
		send_pat(8'h55, 1'b0);
		send_pat(8'h18, 1'b0);
		send_pat(8'h18, 1'b0);
		send_pat(8'h10, 1'b1);
		send_pat(8'h04, 1'b1);
		send_pat(8'h08, 1'b0);
		send_pat(8'h00, 1'b0);
		send_pat(8'h7D, 1'b0);
		send_pat(8'hFE, 1'b0);
		send_pat(8'h00, 1'b1);
		send_pat(8'h3C, 1'b0);
		send_pat(8'h7E, 1'b0);
		send_pat(8'h3E, 1'b0);
		send_pat(8'h60, 1'b0);
		send_item({$urandom, $urandom, $urandom}, 1'b1);
	endtask

	// Mostly well formed tracking runs, with lost runs, restarts and noise mixed in.
	task automatic run_phase(input int n_items);
		int sent, kind, len, k;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 5) == 0) begin
				src_steady = !src_steady;
			end
			kind = $urandom_range(0, 19);
			if (kind < 12) begin
				len = $urandom_range(2, 12);
				for (k = 0; k < len; k++) begin
					send_pat(known_pattern(),
						(k == 0) ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 15) == 0));
				end
			end else if (kind < 14) begin
				len = $urandom_range(1, 4);
				for (k = 0; k < len; k++) begin
					send_pat(CHANNELS'($urandom_range(1, 255)), 1'b0);
				end
			end else if (kind < 17) begin
				if (limit_now < 16 && $urandom_range(0, 1) == 1) begin
					len = limit_now + $urandom_range(1, 3);
				end else begin
					len = $urandom_range(1, 5);
				end
				for (k = 0; k < len; k++) begin
					send_pat('0, 1'b0);
				end
				if ($urandom_range(0, 1) == 1) begin
					send_pat(known_pattern(), 1'b1);
					len++;
				end
			end else if (kind < 18) begin
				len = 1;
				send_pat(CHANNELS'($urandom_range(0, 255)), 1'b1);
			end else begin
				len = $urandom_range(1, 3);
				for (k = 0; k < len; k++) begin
					send_item({$urandom, $urandom, $urandom}, 1'($urandom_range(0, 1)));
				end
			end
			sent += len;
		end
	endtask

	// Output side: random stalls, ready stretches, and one long hold-off on request.
	initial begin
		int stretch;
		m_tready = 1'b0;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (idle_len() > 0) begin
				m_tready <= 1'b0;
				repeat (idle_len() + 1) @(posedge clk);
			end
			m_tready <= 1'b1;
			// A hold-off request cuts the ready stretch short.
			stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
			do begin
				@(posedge clk);
				stretch--;
			end while (stretch > 0 && !hold_off_req);
		end
	end

	// Main sequence.
	initial begin
		int ph, k, waited;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_tvalid      = 1'b0;
		s_tdata       = '0;
		s_tuser       = 1'b0;
		thr_now       = 12'd2400;
		limit_now     = 8'd160;
		src_steady    = 1'b0;
		hold_off_req  = 1'b0;
		settings_used = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		for (ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0: set_cfg(2048, 10, 0, 20, 0, 20, 0);
				1: set_cfg(4095, 20, 20, 20, 20, 0, 3);
				2: set_cfg(0, 5, 0, 20, 7, 9, 6);
				3: set_cfg($urandom_range(1, 4095), 0, 5, 3, 1, 19, 255);
				4: set_cfg($urandom_range(1, 4095), $urandom_range(0, 20), $urandom_range(0, 20),
					$urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
					$urandom_range(0, 30));
				5: set_cfg($urandom_range(0, 4095), $urandom_range(0, 20), $urandom_range(0, 20),
					$urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 20),
					$urandom_range(0, 255));
				default: set_cfg($urandom_range(1, 4095), 10, 2, 16, 8, 14, 160);
			endcase
			case (ph)
				2: run_phase(30);
				3: begin
					// Longest lost run the limit allows, then three more past it.
					for (k = 0; k < int'(limit_now) + 3; k++) begin
						send_pat('0, 1'b0);
					end
					send_pat(known_pattern(), 1'b1);
					run_phase(40);
				end
				4: begin
					// Keep offering while the output side holds off.
					hold_off_req = 1'b1;
					src_steady   = 1'b1;
					run_phase(90);
				end
				default: run_phase(40);
			endcase
		end

		s_tvalid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);

		$display("Covered %0d input transactions under %0d register settings, including a %0d cycle output stall.",
			items_seen, settings_used, HOLD_CYCLES);
		$display("Results: %0d tracking, %0d line lost, %0d exited; %0d unmapped patterns held the last error.",
			track_seen, lost_seen, exit_seen, unknown_seen);
		if (fail_count == 0 && pending == 0) begin
			$display("PASS line_track_steering_pd_top");
		end else begin
			$display("%0d mismatches, %0d results still outstanding", fail_count, pending);
			$display("FAIL line_track_steering_pd_top");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#2000000;
		$display("Timeout with %0d results outstanding", pending);
		$display("FAIL line_track_steering_pd_top");
		$finish;
	end

endmodule

/* line_track_steering_pd_top.f */
design/ltsp_pkg.sv
design/ltsp_regs.sv
design/ltsp_lane.sv
design/ltsp_merge.sv
design/ltsp_ctrl.sv
design/line_track_steering_pd_top.sv
verif/line_track_steering_pd_chk.sv
verif/tb_line_track_steering_pd_top.sv
